// ===== src/utfc_pkg.sv =====
package utfc_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic ADDR_MSB_FIRST = 1'b0;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PAIR,
        KIND_UNIT
    } unit_kind_t;

    typedef struct packed {
        logic       held_emit;
        logic [9:0] held_bits;
        unit_kind_t kind;
        logic [15:0] unit;
    } unit_desc_t;

endpackage

// ===== src/utfc_front.sv =====
module utfc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                msb_first,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          first_byte,
    input  logic [7:0]          second_byte,
    input  logic                last_unit,
    input  logic                q_full,
    output logic                q_push,
    output utfc_pkg::unit_desc_t q_desc
);
    import utfc_pkg::*;

    logic       held_reg;
    logic       held_next;
    logic [9:0] held_bits_reg;
    logic [9:0] held_bits_next;
    logic       ended_reg;
    logic       ended_next;
    logic [15:0] unit;
    logic       is_high;
    logic       is_low;
    logic       accept;
    unit_desc_t desc;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign unit     = msb_first ? {first_byte, second_byte} : {second_byte, first_byte};
    assign is_high  = (unit[15:10] == 6'b110110);
    assign is_low   = (unit[15:10] == 6'b110111);

    always_comb
    begin
        held_next      = held_reg;
        held_bits_next = held_bits_reg;
        ended_next     = ended_reg;
        desc.held_emit = 1'b0;
        desc.held_bits = held_bits_reg;
        desc.kind      = KIND_NONE;
        desc.unit      = unit;
        if (!ended_reg)
        begin
            if (held_reg && is_low)
            begin
                desc.kind = KIND_PAIR;
                held_next = 1'b0;
            end
            else
            begin
                desc.held_emit = held_reg;
                held_next      = 1'b0;
                if (unit == 16'h0000)
                begin
                    ended_next = 1'b1;
                end
                else if (is_high && !last_unit)
                begin
                    held_next      = 1'b1;
                    held_bits_next = unit[9:0];
                end
                else
                begin
                    desc.kind = KIND_UNIT;
                end
            end
        end
        if (last_unit)
        begin
            held_next      = 1'b0;
            held_bits_next = '0;
            ended_next     = 1'b0;
        end
    end

    assign q_desc = desc;
    assign q_push = accept && (desc.held_emit || desc.kind != KIND_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 1'b0;
            ended_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_reg  <= held_next;
            ended_reg <= ended_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_bits_reg <= held_bits_next;
        end
    end

endmodule

// ===== src/utfc_queue.sv =====
module utfc_queue #(
    parameter int DEPTH = utfc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  utfc_pkg::unit_desc_t push_desc,
    input  logic                 pop,
    output logic                 full,
    output logic                 not_empty,
    output utfc_pkg::unit_desc_t head
);
    import utfc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    unit_desc_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== src/utfc_back.sv =====
module utfc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_not_empty,
    input  utfc_pkg::unit_desc_t head,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           utf8_byte,
    output logic                 run_last
);
    import utfc_pkg::*;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } enc_t;

    function automatic enc_t encode(input logic [20:0] cp);
        enc_t e;
        e.bytes = '0;
        if (cp < 21'h80)
        begin
            e.len      = 3'd1;
            e.bytes[0] = cp[7:0];
        end
        else if (cp < 21'h800)
        begin
            e.len      = 3'd2;
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h10000)
        begin
            e.len      = 3'd3;
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            e.len      = 3'd4;
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
        end
        return e;
    endfunction

    logic [20:0] cp_second;
    enc_t        enc_held;
    enc_t        enc_second;
    logic [2:0]  len_held;
    logic [2:0]  len_second;
    logic [2:0]  total;
    logic [7:0]  seq [6];
    logic        advance;
    logic        run_end;

    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  utf8_byte_reg;
    logic [7:0]  utf8_byte_next;
    logic        run_last_reg;
    logic        run_last_next;

    always_comb
    begin
        unique case (head.kind)
            KIND_PAIR: cp_second = 21'h10000 + {1'b0, head.held_bits, head.unit[9:0]};
            KIND_UNIT: cp_second = {5'd0, head.unit};
            default:   cp_second = '0;
        endcase
    end

    assign enc_held   = encode({5'd0, 6'b110110, head.held_bits});
    assign enc_second = encode(cp_second);
    assign len_held   = head.held_emit ? enc_held.len : 3'd0;
    assign len_second = (head.kind == KIND_NONE) ? 3'd0 : enc_second.len;
    assign total      = len_held + len_second;

    // held surrogate bytes first, if any, then the bytes of the new unit
    always_comb
    begin
        if (head.held_emit)
        begin
            seq[0] = enc_held.bytes[0];
            seq[1] = enc_held.bytes[1];
            seq[2] = enc_held.bytes[2];
            seq[3] = enc_second.bytes[0];
            seq[4] = enc_second.bytes[1];
            seq[5] = enc_second.bytes[2];
        end
        else
        begin
            seq[0] = enc_second.bytes[0];
            seq[1] = enc_second.bytes[1];
            seq[2] = enc_second.bytes[2];
            seq[3] = enc_second.bytes[3];
            seq[4] = 8'h00;
            seq[5] = 8'h00;
        end
    end

    assign advance = !out_valid_reg || !out_stall;
    assign run_end = (idx_reg == total - 3'd1);

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        utf8_byte_next = utf8_byte_reg;
        run_last_next  = run_last_reg;
        q_pop          = 1'b0;
        if (advance)
        begin
            out_valid_next = q_not_empty;
            if (q_not_empty)
            begin
                utf8_byte_next = seq[idx_reg];
                run_last_next  = run_end;
                if (run_end)
                begin
                    idx_next = '0;
                    q_pop    = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        utf8_byte_reg <= utf8_byte_next;
        run_last_reg  <= run_last_next;
    end

    assign out_valid = out_valid_reg;
    assign utf8_byte = utf8_byte_reg;
    assign run_last  = run_last_reg;

endmodule

// ===== src/utf16_to_utf8_converter_top.sv =====
// channel   dir   handshake            payload
// input     in    in_valid / in_stall   first_byte, second_byte, last_unit
// output    out   out_valid / out_stall utf8_byte, run_last
// config    in    apb write/read        msb_first at byte address 0
//
// the front takes one code unit per cycle while the queue has room
// the back sends one utf-8 byte per cycle while out_stall is low, so a unit
// gives 1 to 6 bytes there, sent by the byte serializer at the output register
// the first byte of a unit passes the queue entry, then the output register
// units that give no bytes never enter the queue; reset empties queue and state
module utf16_to_utf8_converter_top #(
    parameter int QUEUE_DEPTH = utfc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [utfc_pkg::ADDR_W-1:0] paddr,
    input  logic [utfc_pkg::DATA_W-1:0] pwdata,
    output logic [utfc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  first_byte,
    input  logic [7:0]                  second_byte,
    input  logic                        last_unit,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  utf8_byte,
    output logic                        run_last
);
    import utfc_pkg::*;

    logic       msb_first_reg;
    logic       msb_first_next;
    logic       cfg_hit;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_not_empty;
    unit_desc_t push_desc;
    unit_desc_t head;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[ADDR_W-1] == ADDR_MSB_FIRST);

    always_comb
    begin
        msb_first_next = msb_first_reg;
        if (psel && penable && pwrite && cfg_hit)
        begin
            msb_first_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msb_first_reg <= 1'b0;
        end
        else
        begin
            msb_first_reg <= msb_first_next;
        end
    end

    assign prdata = cfg_hit ? {{(DATA_W-1){1'b0}}, msb_first_reg} : '0;

    utfc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .msb_first   (msb_first_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .last_unit   (last_unit),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_desc      (push_desc)
    );

    utfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head)
    );

    utfc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head        (head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .utf8_byte   (utf8_byte),
        .run_last    (run_last)
    );

endmodule
